/* src/acia_pkg.sv */
// acia_pkg: shared types and codes for the serial register model
// event and result payload structs, event modes, status and control fields
// no dependencies
`timescale 1ns / 1ps

package acia_pkg;

	// event modes
	localparam logic [2:0] MODE_CTRL_WR  = 3'd0;
	localparam logic [2:0] MODE_TX_WR    = 3'd1;
	localparam logic [2:0] MODE_STAT_RD  = 3'd2;
	localparam logic [2:0] MODE_RX_RD    = 3'd3;
	localparam logic [2:0] MODE_LINE_BYTE = 3'd4;
	localparam logic [2:0] MODE_TX_DONE  = 3'd5;
	localparam logic [2:0] MODE_CARRIER  = 3'd6;

	// status register bit positions
	localparam int unsigned ST_RDRF = 0;
	localparam int unsigned ST_TDRE = 1;
	localparam int unsigned ST_DCD  = 2;
	localparam int unsigned ST_CTS  = 3;
	localparam int unsigned ST_FE   = 4;
	localparam int unsigned ST_OVRN = 5;
	localparam int unsigned ST_PE   = 6;
	localparam int unsigned ST_IRQ  = 7;

	// control register fields
	localparam logic [7:0] CTL_DIVIDE = 8'h03;
	localparam logic [7:0] CTL_WORD   = 8'h1c;
	localparam logic [7:0] CTL_TXCTL  = 8'h60;
	localparam logic [7:0] CTL_RIE    = 8'h80;
	localparam logic [7:0] SEVEN_MASK = 8'd127;

	// transmitter control codes
	localparam logic [1:0] TXC_RTS_ON_TIE_OFF = 2'd2;
	localparam logic [1:0] TXC_RTS_OFF_TIE_ON = 2'd1;

	// configuration register indexes
	localparam logic REG_TAPE_SEL = 1'b0;
	localparam logic REG_MOTOR    = 1'b1;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data_in;
		logic       carrier_in;
	} req_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_out;
		logic       rts_out;
		logic       tx_valid;
		logic [7:0] tx_byte;
	} rsp_item_t;

	typedef struct packed {
		logic tape_channel_selected;
		logic motor_relay_on;
	} cfg_t;

endpackage

/* src/acia_cfg_regs.sv */
// acia_cfg_regs: apb-style configuration registers
// holds channel select and motor relay bits; uses acia_pkg
`timescale 1ns / 1ps

module acia_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output acia_pkg::cfg_t    cfg
);
	import acia_pkg::*;

	logic tape_sel_q;
	logic motor_q;
	logic wr_en;
	logic reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tape_sel_q <= 1'b1;
			motor_q    <= 1'b0;
		end else if (wr_en) begin
			if (reg_idx == REG_TAPE_SEL) begin
				tape_sel_q <= pwdata[0];
			end else begin
				motor_q <= pwdata[0];
			end
		end
	end

	always_comb begin
		if (reg_idx == REG_MOTOR) begin
			prdata = {31'd0, motor_q};
		end else begin
			prdata = {31'd0, tape_sel_q};
		end
	end

	assign cfg.tape_channel_selected = tape_sel_q;
	assign cfg.motor_relay_on        = motor_q;

endmodule

/* src/acia_core.sv */
// acia_core: status, receive buffer and transmit holding state
// updates state for one event per step and forms its result; uses acia_pkg
`timescale 1ns / 1ps

module acia_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  acia_pkg::req_item_t   item,
	input  acia_pkg::cfg_t        cfg,
	output acia_pkg::rsp_item_t   result
);
	import acia_pkg::*;

	logic [7:0] status_q, status_d;
	logic [7:0] rx_hold_q, rx_hold_d;
	logic [7:0] rx_shift_q, rx_shift_d;
	logic [1:0] rx_fill_q, rx_fill_d;
	logic [7:0] tx_hold_q, tx_hold_d;
	logic       tx_pending_q, tx_pending_d;
	logic       rie_q, rie_d;
	logic       tie_q, tie_d;
	logic       rts_q, rts_d;
	logic       seven_q, seven_d;
	logic       first_rst_q, first_rst_d;
	logic       prev_car_q, prev_car_d;

	logic [7:0] rd;
	logic       txv;
	logic [7:0] txb;
	logic [1:0] txc;
	logic [1:0] fill_dec;

	always_comb begin
		status_d     = status_q;
		rx_hold_d    = rx_hold_q;
		rx_shift_d   = rx_shift_q;
		rx_fill_d    = rx_fill_q;
		tx_hold_d    = tx_hold_q;
		tx_pending_d = tx_pending_q;
		rie_d        = rie_q;
		tie_d        = tie_q;
		rts_d        = rts_q;
		seven_d      = seven_q;
		first_rst_d  = first_rst_q;
		prev_car_d   = prev_car_q;
		rd           = 8'd0;
		txv          = 1'b0;
		txb          = 8'd0;
		txc          = 2'((item.data_in & CTL_TXCTL) >> 5);
		fill_dec     = (rx_fill_q != 2'd0) ? rx_fill_q - 2'd1 : 2'd0;

		case (item.mode)
			MODE_CTRL_WR: begin
				// master reset keeps only cts, first one after reset also sets it
				if ((item.data_in & CTL_DIVIDE) == CTL_DIVIDE) begin
					status_d = status_q & (8'd1 << ST_CTS);
					if (first_rst_q) begin
						status_d[ST_CTS] = 1'b1;
						first_rst_d      = 1'b0;
					end
					prev_car_d        = 1'b0;
					tx_pending_d      = 1'b0;
					status_d[ST_TDRE] = 1'b1;
				end
				seven_d = ((item.data_in & CTL_WORD) >> 2) < 8'd4;
				rts_d   = (txc == TXC_RTS_ON_TIE_OFF);
				tie_d   = (txc == TXC_RTS_OFF_TIE_ON);
				rie_d   = (item.data_in & CTL_RIE) != 8'd0;
				if (cfg.tape_channel_selected && tie_d && cfg.motor_relay_on) begin
					status_d[ST_IRQ] = 1'b1;
				end
			end
			MODE_TX_WR: begin
				status_d[ST_IRQ]  = 1'b0;
				status_d[ST_TDRE] = 1'b0;
				tx_hold_d         = item.data_in;
				tx_pending_d      = 1'b1;
			end
			MODE_STAT_RD: begin
				rd = status_q;
			end
			MODE_RX_RD: begin
				rd               = seven_q ? (rx_hold_q & SEVEN_MASK) : rx_hold_q;
				status_d[ST_IRQ] = 1'b0;
				rx_hold_d        = rx_shift_q;
				rx_shift_d       = 8'd0;
				rx_fill_d        = fill_dec;
				if (fill_dec == 2'd0) begin
					status_d[ST_RDRF] = 1'b0;
				end else if (rie_q) begin
					status_d[ST_IRQ] = 1'b1;
				end
			end
			MODE_LINE_BYTE: begin
				status_d[ST_OVRN] = 1'b0;
				case (rx_fill_q)
					2'd0: begin
						rx_hold_d = item.data_in;
						rx_fill_d = 2'd1;
					end
					2'd1: begin
						rx_shift_d = item.data_in;
						rx_fill_d  = 2'd2;
					end
					default: begin
						// both full: oldest byte is lost
						rx_hold_d         = rx_shift_q;
						rx_shift_d        = item.data_in;
						rx_fill_d         = 2'd2;
						status_d[ST_OVRN] = 1'b1;
					end
				endcase
				status_d[ST_RDRF] = 1'b1;
				if (rie_q) begin
					status_d[ST_IRQ] = 1'b1;
				end
			end
			MODE_TX_DONE: begin
				if (tx_pending_q) begin
					txv               = 1'b1;
					txb               = tx_hold_q;
					tx_pending_d      = 1'b0;
					status_d[ST_TDRE] = 1'b1;
					if (tie_q) begin
						status_d[ST_IRQ] = 1'b1;
					end
				end
			end
			MODE_CARRIER: begin
				if (cfg.tape_channel_selected) begin
					if (item.carrier_in && !prev_car_q) begin
						if (rie_q) begin
							status_d[ST_IRQ] = 1'b1;
						end
						status_d[ST_DCD] = 1'b1;
					end else if (!item.carrier_in && prev_car_q) begin
						status_d[ST_DCD] = 1'b0;
					end
					prev_car_d = item.carrier_in;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q     <= 8'd0;
			rx_hold_q    <= 8'd0;
			rx_shift_q   <= 8'd0;
			rx_fill_q    <= 2'd0;
			tx_hold_q    <= 8'd0;
			tx_pending_q <= 1'b0;
			rie_q        <= 1'b0;
			tie_q        <= 1'b0;
			rts_q        <= 1'b0;
			seven_q      <= 1'b0;
			first_rst_q  <= 1'b1;
			prev_car_q   <= 1'b1;
		end else if (step) begin
			status_q     <= status_d;
			rx_hold_q    <= rx_hold_d;
			rx_shift_q   <= rx_shift_d;
			rx_fill_q    <= rx_fill_d;
			tx_hold_q    <= tx_hold_d;
			tx_pending_q <= tx_pending_d;
			rie_q        <= rie_d;
			tie_q        <= tie_d;
			rts_q        <= rts_d;
			seven_q      <= seven_d;
			first_rst_q  <= first_rst_d;
			prev_car_q   <= prev_car_d;
		end
	end

	assign result.read_data = rd;
	assign result.irq_out   = status_d[ST_IRQ];
	assign result.rts_out   = rts_d;
	assign result.tx_valid  = txv;
	assign result.tx_byte   = txb;

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		rx_fill_q != 2'd3)
		else $error("receive fill count out of range");

	a_pending_tdre: assert property (@(posedge clk) disable iff (!arst_n)
		tx_pending_q |-> !status_q[ST_TDRE])
		else $error("transmit empty while a byte is pending");

	a_no_frame_err: assert property (@(posedge clk) disable iff (!arst_n)
		!status_q[ST_FE] && !status_q[ST_PE])
		else $error("framing or parity bit set");

	a_first_once: assert property (@(posedge clk) disable iff (!arst_n)
		!first_rst_q |=> !first_rst_q)
		else $error("first master reset flag came back");

endmodule

/* src/acia_serial_register_model.sv */
// acia_serial_register_model: top level of the serial register model
// event register, core update, result register; uses acia_pkg, acia_core, acia_cfg_regs
`timescale 1ns / 1ps

// channel   handshake            payload
// event     req_valid/req_ready  req (mode, data_in, carrier_in)
// result    rsp_valid/rsp_ready  rsp (read_data, irq_out, rts_out, tx_valid, tx_byte)
// config    psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// one event per cycle sustained while the result is not stalled; each event passes
// through the event register and leaves through the result register.
// the core state commits when an event moves from the event to the result register.
// a stalled result holds the result register; the event register still takes one more.
// reset returns the valid flags, core and config state at once, no sweep; payload registers are not reset.

module acia_serial_register_model (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  acia_pkg::req_item_t  req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output acia_pkg::rsp_item_t  rsp,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);
	import acia_pkg::*;

	req_item_t item_s1;
	logic      valid_s1;
	rsp_item_t rsp_s2;
	logic      valid_s2;
	rsp_item_t core_rsp;
	cfg_t      cfg;
	logic      advance;

	// event moves on when the result slot is free or being emptied
	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			item_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= core_rsp;
		end
	end

	acia_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	acia_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (core_rsp)
	);

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

/* sim/tb.sv */
// tb: self-checking bench for acia_serial_register_model
// drives serial events and config writes, predicts every result; uses acia_pkg and the rtl
`timescale 1ns / 1ps

module tb;
	import acia_pkg::*;

	localparam logic [2:0] MODE_IDLE = 3'd7;
	localparam int PHASES = 6;
	localparam int EVENTS_PER_PHASE = 62;

	typedef struct {
		req_item_t ev;
		bit        fixed;
		rsp_item_t val;
	} script_row_t;

	typedef struct {
		bit        fixed;
		rsp_item_t val;
	} pin_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_item_t   req = '0;
	logic        rsp_valid;
	logic        rsp_ready = 1'b0;
	rsp_item_t   rsp;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	acia_serial_register_model dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// shadow of the serial block
	logic [7:0] stat;
	logic [7:0] rx_front, rx_back, tx_latch;
	logic [1:0] rx_count;
	logic       tx_busy, rx_int_en, tx_int_en, rts_line, word7, first_mr, dcd_prev;
	logic       cfg_tape, cfg_motor;

	rsp_item_t  awaited_rsp[$];
	pin_t       pin_q[$];
	int         mismatches = 0;
	int         burst_left = 0;

	task automatic shadow_reset();
		stat = '0; rx_front = '0; rx_back = '0; tx_latch = '0; rx_count = '0;
		tx_busy = 0; rx_int_en = 0; tx_int_en = 0; rts_line = 0; word7 = 0;
		first_mr = 1; dcd_prev = 1; cfg_tape = 1; cfg_motor = 0;
	endtask

	task automatic advance_acia(input req_item_t ev, output rsp_item_t res);
		logic [7:0] rd;
		logic [7:0] txc;
		logic       txv;
		logic [7:0] txb;
		rd = '0; txv = 0; txb = '0;
		case (ev.mode)
			MODE_CTRL_WR: begin
				if ((ev.data_in & CTL_DIVIDE) == CTL_DIVIDE) begin
					// master reset keeps only cts
					stat = stat & (8'd1 << ST_CTS);
					if (first_mr) begin
						stat[ST_CTS] = 1'b1;
						first_mr = 0;
					end
					dcd_prev = 0;
					tx_busy = 0;
					stat[ST_TDRE] = 1'b1;
				end
				word7 = (((ev.data_in & CTL_WORD) >> 2) < 8'd4);
				txc = (ev.data_in & CTL_TXCTL) >> 5;
				rts_line = (txc[1:0] == TXC_RTS_ON_TIE_OFF);
				tx_int_en = (txc[1:0] == TXC_RTS_OFF_TIE_ON);
				rx_int_en = |(ev.data_in & CTL_RIE);
				if (cfg_tape && tx_int_en && cfg_motor)
					stat[ST_IRQ] = 1'b1;
			end
			MODE_TX_WR: begin
				stat[ST_IRQ] = 1'b0;
				tx_latch = ev.data_in;
				tx_busy = 1;
				stat[ST_TDRE] = 1'b0;
			end
			MODE_STAT_RD: rd = stat;
			MODE_RX_RD: begin
				rd = rx_front;
				stat[ST_IRQ] = 1'b0;
				rx_front = rx_back;
				rx_back = '0;
				if (rx_count != 0)
					rx_count = rx_count - 2'd1;
				if (rx_count == 0)
					stat[ST_RDRF] = 1'b0;
				else if (rx_int_en)
					stat[ST_IRQ] = 1'b1;
				if (word7)
					rd = rd & SEVEN_MASK;
			end
			MODE_LINE_BYTE: begin
				stat[ST_OVRN] = 1'b0;
				if (rx_count == 0) begin
					rx_front = ev.data_in;
					rx_count = 2'd1;
				end else if (rx_count == 1) begin
					rx_back = ev.data_in;
					rx_count = 2'd2;
				end else begin
					// both slots full: oldest byte is lost
					rx_front = rx_back;
					rx_back = ev.data_in;
					stat[ST_OVRN] = 1'b1;
				end
				stat[ST_RDRF] = 1'b1;
				if (rx_int_en)
					stat[ST_IRQ] = 1'b1;
			end
			MODE_TX_DONE: begin
				if (tx_busy) begin
					txv = 1;
					txb = tx_latch;
					tx_busy = 0;
					stat[ST_TDRE] = 1'b1;
					if (tx_int_en)
						stat[ST_IRQ] = 1'b1;
				end
			end
			MODE_CARRIER: begin
				if (cfg_tape) begin
					if (ev.carrier_in && !dcd_prev) begin
						if (rx_int_en)
							stat[ST_IRQ] = 1'b1;
						stat[ST_DCD] = 1'b1;
					end else if (!ev.carrier_in && dcd_prev) begin
						stat[ST_DCD] = 1'b0;
					end
					dcd_prev = ev.carrier_in;
				end
			end
			default: ;
		endcase
		res.read_data = rd;
		res.irq_out = stat[ST_IRQ];
		res.rts_out = rts_line;
		res.tx_valid = txv;
		res.tx_byte = txb;
	endtask

	// event transfer: predict at acceptance, in order
	always @(posedge clk) begin : accept_mon
		rsp_item_t r;
		pin_t p;
		if (arst_n && req_valid && req_ready) begin
			advance_acia(req, r);
			p = pin_q.pop_front();
			awaited_rsp.push_back(p.fixed ? p.val : r);
		end
	end

	task automatic cmp_field(input string name, input logic [7:0] e, input logic [7:0] a);
		if (e !== a) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_mon
		rsp_item_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				$error("result transfer with nothing outstanding");
				mismatches++;
			end else begin
				e = awaited_rsp.pop_front();
				cmp_field("read_data", e.read_data, rsp.read_data);
				cmp_field("irq_out", 8'(e.irq_out), 8'(rsp.irq_out));
				cmp_field("rts_out", 8'(e.rts_out), 8'(rsp.rts_out));
				cmp_field("tx_valid", 8'(e.tx_valid), 8'(rsp.tx_valid));
				cmp_field("tx_byte", e.tx_byte, rsp.tx_byte);
			end
		end
	end

	// receiver back-pressure in one of four randomly chosen styles
	int unsigned rx_cyc = 0;
	int unsigned stall_style = 0;
	int unsigned stall_left = 0;
	always @(posedge clk) begin
		rx_cyc++;
		if (rx_cyc % 64 == 0)
			stall_style = $urandom_range(0, 3);
		case (stall_style)
			0: rsp_ready <= 1'b1;
			1: rsp_ready <= ($urandom_range(0, 2) != 0);
			2: rsp_ready <= (rx_cyc % 5 != 0);
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					rsp_ready <= 1'b0;
				end else begin
					if ($urandom_range(0, 7) == 0)
						stall_left = $urandom_range(3, 12);
					rsp_ready <= 1'b1;
				end
			end
		endcase
	end

	task automatic issue(input req_item_t ev, input bit fixed, input rsp_item_t val);
		int gap;
		pin_t p;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		p.fixed = fixed;
		p.val = val;
		pin_q.push_back(p);
		req <= ev;
		req_valid <= 1'b1;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0 || pin_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= {31'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (idx == REG_TAPE_SEL)
			cfg_tape = val;
		else
			cfg_motor = val;
		penable <= 1'b0; pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[0] !== val) begin
			$error("prdata: expected %0h, got %0h", val, prdata[0]);
			mismatches++;
		end
		psel <= 1'b0; penable <= 1'b0;
	endtask

	function automatic req_item_t pick_event();
		req_item_t ev;
		int unsigned w;
		ev.data_in = 8'($urandom_range(0, 255));
		ev.carrier_in = 1'($urandom_range(0, 1));
		w = $urandom_range(0, 99);
		if (w < 8) begin
			ev.mode = MODE_CTRL_WR;
			if ($urandom_range(0, 1))
				ev.data_in = ev.data_in | CTL_DIVIDE;
		end else if (w < 22) ev.mode = MODE_TX_WR;
		else if (w < 36) ev.mode = MODE_STAT_RD;
		else if (w < 54) ev.mode = MODE_RX_RD;
		else if (w < 74) ev.mode = MODE_LINE_BYTE;
		else if (w < 86) ev.mode = MODE_TX_DONE;
		else if (w < 98) ev.mode = MODE_CARRIER;
		else ev.mode = MODE_IDLE;
		return ev;
	endfunction

	script_row_t script[$] = '{
		'{'{MODE_STAT_RD, 8'h00, 1'b0}, 1, '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00}},
		'{'{MODE_TX_DONE, 8'hff, 1'b1}, 1, '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00}},
		'{'{MODE_RX_RD, 8'h00, 1'b0}, 1, '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00}},
		'{'{MODE_CTRL_WR, 8'h03, 1'b0}, 1, '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00}},
		'{'{MODE_STAT_RD, 8'h00, 1'b0}, 1, '{8'h0a, 1'b0, 1'b0, 1'b0, 8'h00}},
		'{'{MODE_CTRL_WR, 8'h95, 1'b0}, 0, '0},
		'{'{MODE_LINE_BYTE, 8'hff, 1'b0}, 0, '0},
		'{'{MODE_LINE_BYTE, 8'h00, 1'b1}, 0, '0},
		'{'{MODE_LINE_BYTE, 8'h80, 1'b0}, 0, '0},
		'{'{MODE_STAT_RD, 8'h00, 1'b0}, 0, '0},
		'{'{MODE_RX_RD, 8'h00, 1'b0}, 0, '0},
		'{'{MODE_RX_RD, 8'h00, 1'b0}, 0, '0},
		'{'{MODE_RX_RD, 8'h00, 1'b0}, 0, '0},
		'{'{MODE_CTRL_WR, 8'h43, 1'b0}, 0, '0},
		'{'{MODE_LINE_BYTE, 8'hff, 1'b0}, 0, '0},
		'{'{MODE_RX_RD, 8'h00, 1'b0}, 1, '{8'h7f, 1'b0, 1'b1, 1'b0, 8'h00}},
		'{'{MODE_CTRL_WR, 8'h23, 1'b0}, 0, '0},
		'{'{MODE_TX_WR, 8'ha5, 1'b0}, 0, '0},
		'{'{MODE_TX_WR, 8'h5a, 1'b0}, 0, '0},
		'{'{MODE_TX_DONE, 8'h00, 1'b0}, 1, '{8'h00, 1'b1, 1'b0, 1'b1, 8'h5a}},
		'{'{MODE_TX_DONE, 8'h00, 1'b0}, 0, '0},
		'{'{MODE_CARRIER, 8'h00, 1'b1}, 0, '0},
		'{'{MODE_CARRIER, 8'h00, 1'b0}, 0, '0},
		'{'{MODE_STAT_RD, 8'h00, 1'b0}, 0, '0},
		'{'{MODE_IDLE, 8'hff, 1'b1}, 0, '0}
	};

	// tape select / motor relay per phase, extremes included
	logic phase_tape[PHASES]  = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
	logic phase_motor[PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

	initial begin
		shadow_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (script[i])
			issue(script[i].ev, script[i].fixed, script[i].val);
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			set_reg(REG_TAPE_SEL, phase_tape[ph]);
			set_reg(REG_MOTOR, phase_motor[ph]);
			for (int n = 0; n < EVENTS_PER_PHASE; n++) begin
				// in phase 1, hold off until the block is empty once mid-phase
				if (ph == 1 && n == EVENTS_PER_PHASE / 2)
					drain();
				issue(pick_event(), 0, '0);
			end
		end
		drain();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && awaited_rsp.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#400000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
